// ----- design/swft_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package swft_pkg;

  // frame and table sizes
  localparam int unsigned DEVICE_PINS  = 12;
  localparam int unsigned PATH_ENTRIES = 7;
  localparam int unsigned FRAME_W      = 14;
  localparam int unsigned CTRL_MAX     = 8;
  localparam int unsigned PATH_MAX     = 4;

  // input word kinds carried on tuser
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_QUEUE = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_WORK_PERIOD     = 3'd0;
  localparam logic [2:0] REG_CONTROLLER_BITS = 3'd1;
  localparam logic [2:0] REG_PATH_BITS       = 3'd2;
  localparam logic [2:0] REG_NODE_NUMBER     = 3'd3;
  localparam logic [2:0] REG_DEVICE_COUNT    = 3'd4;
  localparam logic [2:0] REG_CONTROLLER_TYPE = 3'd5;

  // controller types
  localparam logic CTYPE_LIGHTS = 1'b0;
  localparam logic CTYPE_ARROWS = 1'b1;

  // path tables, one device level word per path
  localparam logic [DEVICE_PINS-1:0] LIGHT_PATHS [PATH_ENTRIES] = '{
    12'b100000000000, 12'b011100000000, 12'b011010000000, 12'b010001110000,
    12'b010001101000, 12'b010001000110, 12'b010001000101
  };
  localparam logic [DEVICE_PINS-1:0] ARROW_PATHS [PATH_ENTRIES] = '{
    12'b000000100000, 12'b000000011000, 12'b000000001000, 12'b000000000000,
    12'b000000000100, 12'b000000000010, 12'b000000000011
  };

  // device levels for a path, zero past the end of the table
  function automatic logic [DEVICE_PINS-1:0] path_levels(input logic ctype,
                                                         input logic [3:0] path);
    logic [DEVICE_PINS-1:0] lv;
    lv = '0;
    if (32'(path) < PATH_ENTRIES) begin
      if (ctype == CTYPE_ARROWS) begin
        lv = ARROW_PATHS[path[2:0]];
      end else begin
        lv = LIGHT_PATHS[path[2:0]];
      end
    end
    return lv;
  endfunction

  // low-bit mask of a given width inside a frame word
  function automatic logic [FRAME_W-1:0] low_mask(input logic [3:0] width);
    logic [FRAME_W:0] one_hot;
    one_hot = (FRAME_W+1)'(1) << width;
    return FRAME_W'(one_hot - (FRAME_W+1)'(1));
  endfunction

endpackage

`default_nettype wire

// ----- design/single_wire_frame_transceiver.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Half-duplex single-wire frame transceiver. Each input word is either a
// millisecond tick carrying the sampled bus level, or a request to queue a
// frame (start 1, controller number, path number, stop 0, sent MSB first).
// One result word comes back per input word. The block takes one word per
// clock: all the work for a word is done in one pass of shallow logic into
// the output register, and a new word is taken whenever that register is
// empty or being drained in the same cycle. Configuration writes go through the plain
// write port; the user must make them only while the stream is idle, which is not checked.
module single_wire_frame_transceiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // bus_in, dest_controller[7:0], dest_path[3:0], zero fill
  input  logic        s_axis_tuser,   // op
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // bus_out, bus_drive, sending, receiving, frame_ok,
                                      // frame_error, addressed_here, device_levels[11:0],
                                      // zero fill
);

  localparam int unsigned FW = swft_pkg::FRAME_W;
  localparam int unsigned DP = swft_pkg::DEVICE_PINS;

  // configuration registers
  logic [15:0] work_period_q;
  logic [3:0]  ctrl_bits_q;
  logic [2:0]  path_bits_q;
  logic [7:0]  node_number_q;
  logic [3:0]  device_count_q;
  logic        ctrl_type_q;

  // transceiver state
  logic [FW-1:0] tx_frame_q, tx_frame_d;
  logic [FW-1:0] tx_mask_q, tx_mask_d;
  logic          tx_active_q, tx_active_d;
  logic [FW-1:0] rx_shift_q, rx_shift_d;
  logic          rx_active_q, rx_active_d;
  logic [15:0]   elapsed_q, elapsed_d;
  logic [DP-1:0] levels_q, levels_d;
  logic          line_q, line_d;

  // output register
  logic        out_valid_q;
  logic [23:0] out_data_q, out_data_d;

  logic          accept;
  logic          in_bus;
  logic [7:0]    in_ctrl;
  logic [3:0]    in_path;
  logic [3:0]    frame_len;
  logic [FW-1:0] start_bit;
  logic [3:0]    path_shift;
  logic [FW-1:0] rx_next;
  logic [FW-1:0] cur_mask;
  logic [FW-1:0] ctrl_word;
  logic [FW-1:0] path_word;
  logic [3:0]    dev_n;
  logic [DP-1:0] dev_mask;
  logic [DP-1:0] entry;
  logic          drive, ok, err, addressed;
  logic [3:0]    wr_cb;
  logic [2:0]    wr_pb;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign in_bus  = s_axis_tdata[0];
  assign in_ctrl = s_axis_tdata[8:1];
  assign in_path = s_axis_tdata[12:9];

  // frame geometry from the field widths
  assign frame_len  = ctrl_bits_q + 4'(path_bits_q) + 4'd1;
  assign start_bit  = FW'(1) << frame_len;
  assign path_shift = 4'(path_bits_q) + 4'd1;

  // received fields and the device update mask
  assign ctrl_word = (rx_next >> path_shift) & swft_pkg::low_mask(ctrl_bits_q);
  assign path_word = (rx_next >> 1) & swft_pkg::low_mask(4'(path_bits_q));
  assign dev_n     = (32'(device_count_q) > DP) ? 4'(DP) : device_count_q;
  assign dev_mask  = DP'(swft_pkg::low_mask(dev_n));
  assign entry     = swft_pkg::path_levels(ctrl_type_q, path_word[3:0]);

  // one pass: queue or tick, send phase then receive phase
  always_comb begin
    tx_frame_d  = tx_frame_q;
    tx_mask_d   = tx_mask_q;
    tx_active_d = tx_active_q;
    rx_shift_d  = rx_shift_q;
    rx_active_d = rx_active_q;
    elapsed_d   = elapsed_q;
    levels_d    = levels_q;
    line_d      = line_q;
    drive       = 1'b0;
    ok          = 1'b0;
    err         = 1'b0;
    addressed   = 1'b0;
    rx_next     = {rx_shift_q[FW-2:0], in_bus};
    cur_mask    = tx_active_q ? tx_mask_q : start_bit;

    if (s_axis_tuser == swft_pkg::OP_QUEUE) begin
      tx_frame_d = start_bit
                 | ((FW'(in_ctrl) & swft_pkg::low_mask(ctrl_bits_q)) << path_shift)
                 | ((FW'(in_path) & swft_pkg::low_mask(4'(path_bits_q))) << 1);
    end else begin
      if (elapsed_q != 16'hFFFF) begin
        elapsed_d = elapsed_q + 16'd1;
      end
      // send phase
      if (tx_frame_q != '0) begin
        drive = 1'b1;
        if (elapsed_d >= work_period_q) begin
          elapsed_d = '0;
          if (!rx_active_q) begin
            tx_active_d = 1'b1;
            line_d      = |(tx_frame_q & cur_mask);
            tx_mask_d   = cur_mask >> 1;
            if (tx_mask_d == '0) begin
              tx_active_d = 1'b0;
              tx_frame_d  = '0;
            end
          end
        end
      end
      // receive phase, only while not sending
      if (!tx_active_d) begin
        if (!rx_active_q) begin
          if (in_bus) begin
            rx_shift_d  = FW'(1);
            rx_active_d = 1'b1;
            elapsed_d   = '0;
          end
        end else if (elapsed_d >= work_period_q) begin
          elapsed_d  = '0;
          rx_shift_d = rx_next;
          if (rx_next >= start_bit) begin
            if (!rx_next[0]) begin
              ok = 1'b1;
              if (ctrl_word[7:0] == node_number_q) begin
                addressed = 1'b1;
                levels_d  = (levels_q & ~dev_mask) | (entry & dev_mask);
              end
            end else begin
              err = 1'b1;
            end
            rx_active_d = 1'b0;
            rx_shift_d  = '0;
          end
        end
      end
    end

    out_data_d = {5'd0, levels_d, addressed, err, ok, rx_active_d, tx_active_d,
                  drive, drive && line_d};
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_frame_q  <= '0;
      tx_mask_q   <= '0;
      tx_active_q <= 1'b0;
      rx_shift_q  <= '0;
      rx_active_q <= 1'b0;
      elapsed_q   <= '0;
      levels_q    <= '0;
      line_q      <= 1'b0;
    end else if (accept) begin
      tx_frame_q  <= tx_frame_d;
      tx_mask_q   <= tx_mask_d;
      tx_active_q <= tx_active_d;
      rx_shift_q  <= rx_shift_d;
      rx_active_q <= rx_active_d;
      elapsed_q   <= elapsed_d;
      levels_q    <= levels_d;
      line_q      <= line_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  // write values with zero widths ignored and large widths saturated
  assign wr_cb = (cfg_wdata_i[3:0] > 4'(swft_pkg::CTRL_MAX)) ? 4'(swft_pkg::CTRL_MAX)
                                                             : cfg_wdata_i[3:0];
  assign wr_pb = (cfg_wdata_i[2:0] > 3'(swft_pkg::PATH_MAX)) ? 3'(swft_pkg::PATH_MAX)
                                                             : cfg_wdata_i[2:0];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_period_q  <= 16'd10;
      ctrl_bits_q    <= 4'd2;
      path_bits_q    <= 3'd4;
      node_number_q  <= 8'd0;
      device_count_q <= 4'd12;
      ctrl_type_q    <= swft_pkg::CTYPE_LIGHTS;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        swft_pkg::REG_WORK_PERIOD: work_period_q <= cfg_wdata_i;
        swft_pkg::REG_CONTROLLER_BITS: begin
          if (cfg_wdata_i[3:0] != 4'd0) begin
            ctrl_bits_q <= wr_cb;
          end
        end
        swft_pkg::REG_PATH_BITS: begin
          if (cfg_wdata_i[2:0] != 3'd0) begin
            path_bits_q <= wr_pb;
          end
        end
        swft_pkg::REG_NODE_NUMBER:     node_number_q  <= cfg_wdata_i[7:0];
        swft_pkg::REG_DEVICE_COUNT:    device_count_q <= cfg_wdata_i[3:0];
        swft_pkg::REG_CONTROLLER_TYPE: ctrl_type_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // sender and receiver never run together
  a_half_duplex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tx_active_q && rx_active_q))
    else $error("send and receive active at once");

  // an active send always has a pending frame
  a_tx_has_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_active_q |-> (tx_frame_q != '0))
    else $error("send active with no frame pending");

  // a completed frame is either good or bad, and only good frames are taken
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!(out_data_q[4] && out_data_q[5]) && (!out_data_q[6] || out_data_q[4])))
    else $error("inconsistent frame flags");

  // an idle receiver holds a cleared shift register
  a_rx_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_active_q |-> (rx_shift_q == '0))
    else $error("receiver idle with data in shift register");

endmodule

`default_nettype wire

// ----- tb/single_wire_frame_transceiver_tb.sv -----
`timescale 1ns / 1ps

module single_wire_frame_transceiver_tb;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned HOLD_LEN   = 250;
  localparam int unsigned PHASE_LEN  = 215;
  localparam int unsigned ERR_PRINTS = 100;

  typedef struct packed {
    logic       op;
    logic       bus;
    logic [7:0] dest_ctrl;
    logic [3:0] dest_path;
  } line_word_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_addr_i    = '0;
  logic [15:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // bus_in, dest_controller[7:0], dest_path[3:0], zero fill
  logic        s_axis_tuser  = 1'b0; // op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // bus_out, bus_drive, sending, receiving, frame_ok,
                                     // frame_error, addressed_here, device_levels[11:0],
                                     // zero fill

  single_wire_frame_transceiver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow of the configuration registers
  logic [15:0] cfg_period;
  logic [3:0]  cfg_ctrl_w;
  logic [2:0]  cfg_path_w;
  logic [7:0]  cfg_node;
  logic [3:0]  cfg_devices;
  logic        cfg_ctype;

  // transceiver state as the block should hold it
  logic [13:0] tx_word;
  logic [13:0] tx_sel;
  logic [13:0] rx_word;
  logic        tx_busy;
  logic        rx_busy;
  logic        line_lvl;
  logic [15:0] tick_cnt;
  logic [11:0] levels_q;

  line_word_t  line_words[$];
  logic [23:0] expected_status[$];
  line_word_t  drv_word;
  logic [23:0] want;
  logic        ready_next;
  int unsigned in_gap, in_run, out_wait, out_run, hold_left;
  logic        in_calm, out_calm;
  int unsigned in_count, result_count, fail_count, planned;
  int unsigned idle_cycles, last_moves;

  function automatic void reset_model();
    cfg_period  = 16'd10;
    cfg_ctrl_w  = 4'd2;
    cfg_path_w  = 3'd4;
    cfg_node    = 8'd0;
    cfg_devices = 4'd12;
    cfg_ctype   = swft_pkg::CTYPE_LIGHTS;
    tx_word     = '0;
    tx_sel      = '0;
    rx_word     = '0;
    tx_busy     = 1'b0;
    rx_busy     = 1'b0;
    line_lvl    = 1'b0;
    tick_cnt    = '0;
    levels_q    = '0;
  endfunction

  function automatic void shadow_write(logic [2:0] idx, logic [15:0] v);
    case (idx)
      swft_pkg::REG_WORK_PERIOD:     cfg_period = v;
      swft_pkg::REG_CONTROLLER_BITS: if (v[3:0] != 0) cfg_ctrl_w = (v[3:0] > 8) ? 4'd8 : v[3:0];
      swft_pkg::REG_PATH_BITS:       if (v[2:0] != 0) cfg_path_w = (v[2:0] > 4) ? 3'd4 : v[2:0];
      swft_pkg::REG_NODE_NUMBER:     cfg_node = v[7:0];
      swft_pkg::REG_DEVICE_COUNT:    cfg_devices = v[3:0];
      swft_pkg::REG_CONTROLLER_TYPE: cfg_ctype = v[0];
      default: ;
    endcase
  endfunction

  // device levels of one path, per controller type
  function automatic logic [11:0] route_levels(logic ctype, int unsigned path);
    logic [11:0] lv;
    lv = '0;
    if (ctype == swft_pkg::CTYPE_ARROWS) begin
      case (path)
        0: lv = 12'h020;
        1: lv = 12'h018;
        2: lv = 12'h008;
        4: lv = 12'h004;
        5: lv = 12'h002;
        6: lv = 12'h003;
        default: lv = '0;
      endcase
    end else begin
      case (path)
        0: lv = 12'h800;
        1: lv = 12'h700;
        2: lv = 12'h680;
        3: lv = 12'h470;
        4: lv = 12'h468;
        5: lv = 12'h446;
        6: lv = 12'h445;
        default: lv = '0;
      endcase
    end
    return lv;
  endfunction

  // advance the transceiver by one word and return the status word it yields
  function automatic logic [23:0] line_status(line_word_t w);
    int unsigned len, cmask, pmask, ctrl, path, ndev, dmask, entry;
    logic drive, ok, err, hit;
    len   = cfg_ctrl_w + cfg_path_w + 32'd1;
    cmask = (32'd1 << cfg_ctrl_w) - 32'd1;
    pmask = (32'd1 << cfg_path_w) - 32'd1;
    drive = 1'b0;
    ok    = 1'b0;
    err   = 1'b0;
    hit   = 1'b0;
    if (w.op == swft_pkg::OP_QUEUE) begin
      tx_word = 14'((32'd1 << len) | ((w.dest_ctrl & cmask) << (cfg_path_w + 32'd1))
                    | ((w.dest_path & pmask) << 1));
    end else begin
      if (tick_cnt != 16'hFFFF) tick_cnt = tick_cnt + 16'd1;
      // send side, sharing the bit timer with the receiver
      if (tx_word != 0) begin
        drive = 1'b1;
        if (tick_cnt >= cfg_period) begin
          tick_cnt = '0;
          if (!rx_busy) begin
            if (!tx_busy) begin
              tx_busy = 1'b1;
              tx_sel  = 14'(32'd1 << len);
            end
            line_lvl = (tx_word & tx_sel) != 0;
            tx_sel   = tx_sel >> 1;
            if (tx_sel == 0) begin
              tx_busy = 1'b0;
              tx_word = '0;
            end
          end
        end
      end
      // receive side, only while not sending
      if (!tx_busy) begin
        if (!rx_busy) begin
          if (w.bus) begin
            rx_word  = 14'd1;
            rx_busy  = 1'b1;
            tick_cnt = '0;
          end
        end else if (tick_cnt >= cfg_period) begin
          tick_cnt = '0;
          rx_word  = {rx_word[12:0], w.bus};
          if (rx_word >= (32'd1 << len)) begin
            if (!rx_word[0]) begin
              ok   = 1'b1;
              ctrl = (rx_word >> (cfg_path_w + 32'd1)) & cmask;
              path = (rx_word >> 1) & pmask;
              if (ctrl == cfg_node) begin
                hit   = 1'b1;
                entry = (path < swft_pkg::PATH_ENTRIES) ? route_levels(cfg_ctype, path) : 0;
                ndev  = (cfg_devices > swft_pkg::DEVICE_PINS) ? swft_pkg::DEVICE_PINS
                                                              : cfg_devices;
                dmask = (32'd1 << ndev) - 32'd1;
                levels_q = 12'((levels_q & ~dmask) | (entry & dmask));
              end
            end else begin
              err = 1'b1;
            end
            rx_busy = 1'b0;
            rx_word = '0;
          end
        end
      end
    end
    return {5'b0, levels_q, hit, err, ok, rx_busy, tx_busy, drive, drive & line_lvl};
  endfunction

  // wait per word, with calm stretches of no idling now and then
  function automatic int unsigned draw_gap(inout int unsigned run, inout logic calm);
    if (run == 0) begin
      calm = ($urandom_range(0, 2) == 0);
      run  = $urandom_range(20, 80);
    end
    run--;
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  task automatic check_field(input string name, input logic [11:0] exp_v,
                             input logic [11:0] act_v);
    if (exp_v !== act_v) begin
      if (fail_count < ERR_PRINTS) $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  function automatic logic work_left();
    return line_words.size() != 0 || s_axis_tvalid || expected_status.size() != 0;
  endfunction

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_status.push_back(line_status(line_word_t'{s_axis_tuser, s_axis_tdata[0],
                                                           s_axis_tdata[8:1],
                                                           s_axis_tdata[12:9]}));
        in_count++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (in_gap != 0) begin
          in_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (line_words.size() != 0) begin
          drv_word = line_words.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {3'b0, drv_word.dest_path, drv_word.dest_ctrl, drv_word.bus};
          s_axis_tuser  <= drv_word.op;
          in_gap = draw_gap(in_run, in_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      ready_next = 1'b1;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_status.size() == 0) begin
          if (fail_count < ERR_PRINTS) $error("unexpected result word %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_status.pop_front();
          check_field("bus_out", want[0], m_axis_tdata[0]);
          check_field("bus_drive", want[1], m_axis_tdata[1]);
          check_field("sending", want[2], m_axis_tdata[2]);
          check_field("receiving", want[3], m_axis_tdata[3]);
          check_field("frame_ok", want[4], m_axis_tdata[4]);
          check_field("frame_error", want[5], m_axis_tdata[5]);
          check_field("addressed_here", want[6], m_axis_tdata[6]);
          check_field("device_levels", want[18:7], m_axis_tdata[18:7]);
        end
        result_count++;
        out_wait = draw_gap(out_run, out_calm);
        // long hold-offs so the block backs up into its input
        if (result_count == 350 || result_count == 1000) hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (out_wait != 0) begin
        out_wait--;
        ready_next = 1'b0;
      end
      m_axis_tready <= ready_next;
    end
  end

  // watchdog on cycles with work left but no word moving
  initial begin
    idle_cycles = 0;
    last_moves  = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(negedge clk_i);
      if (in_count + result_count != last_moves || !work_left()) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      last_moves = in_count + result_count;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic wait_drained();
    @(negedge clk_i);
    while (work_left()) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // register write with random bits above the register width
  task automatic write_reg(input logic [2:0] idx, input int unsigned value,
                           input int unsigned width);
    logic [15:0] wd;
    wd = 16'(value | ($urandom << width));
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= wd;
    shadow_write(idx, wd);
  endtask

  task automatic configure(input int unsigned period, input int unsigned cbits,
                           input int unsigned pbits, input int unsigned node,
                           input int unsigned devs, input int unsigned ctype);
    wait_drained();
    write_reg(swft_pkg::REG_WORK_PERIOD, period, 16);
    write_reg(swft_pkg::REG_CONTROLLER_BITS, cbits, 4);
    write_reg(swft_pkg::REG_PATH_BITS, pbits, 3);
    write_reg(swft_pkg::REG_NODE_NUMBER, node, 8);
    write_reg(swft_pkg::REG_DEVICE_COUNT, devs, 4);
    write_reg(swft_pkg::REG_CONTROLLER_TYPE, ctype, 1);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic void push_word(logic op, logic bus, logic [7:0] dc, logic [3:0] dp);
    line_words.push_back(line_word_t'{op, bus, dc, dp});
    planned++;
  endfunction

  function automatic void push_tick(logic bus);
    push_word(swft_pkg::OP_TICK, bus, 8'($urandom), 4'($urandom));
  endfunction

  function automatic void push_send(logic [7:0] dc, logic [3:0] dp);
    push_word(swft_pkg::OP_QUEUE, 1'($urandom), dc, dp);
  endfunction

  function automatic int unsigned bit_period();
    return (cfg_period == 0) ? 1 : cfg_period;
  endfunction

  // frame on the line: start sample, then one sample per bit period, with
  // random levels on the ticks in between; keep cuts it short, and a send
  // request can be slipped in before bit send_at
  function automatic void push_frame(int unsigned ctrl, int unsigned path, logic good_stop,
                                     int unsigned keep, int unsigned send_at);
    int unsigned nbits, bits, per;
    nbits = cfg_ctrl_w + cfg_path_w + 32'd1;
    bits  = ((ctrl & ((32'd1 << cfg_ctrl_w) - 1)) << (cfg_path_w + 32'd1))
            | ((path & ((32'd1 << cfg_path_w) - 1)) << 1) | (good_stop ? 0 : 1);
    per   = bit_period();
    push_tick(1'b1);
    for (int unsigned k = 0; k < nbits && k < keep; k++) begin
      if (k == send_at) push_send(8'($urandom), 4'($urandom));
      repeat (per - 1) push_tick(1'($urandom));
      push_tick(1'((bits >> (nbits - 1 - k)) & 1));
    end
  endfunction

  task automatic fill_random(input int unsigned count);
    int unsigned stop_at, pick, ctrl, len;
    stop_at = planned + count;
    while (planned < stop_at) begin
      pick = $urandom_range(0, 99);
      ctrl = ($urandom_range(0, 1) == 0) ? cfg_node : $urandom_range(0, 255);
      len  = cfg_ctrl_w + cfg_path_w + 32'd1;
      if (pick < 55) begin
        push_frame(ctrl, $urandom_range(0, 15), $urandom_range(0, 6) != 0, len, len);
      end else if (pick < 63) begin
        // broken frame, then line noise
        push_frame(ctrl, $urandom_range(0, 15), 1'($urandom), $urandom_range(0, len - 1), len);
        repeat ($urandom_range(1, 6)) push_tick(1'($urandom));
      end else if (pick < 70) begin
        // send request while a reception is under way
        push_frame(ctrl, $urandom_range(0, 15), 1'b1, len, $urandom_range(0, len - 1));
      end else if (pick < 88) begin
        push_send(8'($urandom), 4'($urandom));
        if ($urandom_range(0, 3) == 0) begin
          // replace the frame while it is partly out
          repeat ($urandom_range(1, len * bit_period())) push_tick(1'b0);
          push_send(8'($urandom), 4'($urandom));
        end
        repeat ((len + 2) * bit_period()) push_tick(1'b0);
      end else begin
        repeat ($urandom_range(1, 8)) push_tick(1'($urandom));
      end
      if (pick < 70) repeat ($urandom_range(0, 2)) push_tick(1'b0);
    end
  endtask

  // stimulus
  initial begin
    reset_model();
    in_count = 0;
    result_count = 0;
    fail_count = 0;
    planned = 0;
    in_run = 0;
    out_run = 0;
    out_wait = 0;
    hold_left = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, quiet line
    push_tick(1'b0);
    push_tick(1'b0);

    // directed: path past the table, bad stop bit, send request with all-ones fields
    configure(1, 1, 3, 1, 12, swft_pkg::CTYPE_LIGHTS);
    push_tick(1'b0);
    push_frame(1, 7, 1'b1, 99, 99);
    push_frame(1, 2, 1'b1, 99, 99);
    push_frame(1, 3, 1'b0, 99, 99);
    push_send(8'hFF, 4'hF);
    repeat (7) push_tick(1'b0);

    configure(1, 2, 4, 2, 12, swft_pkg::CTYPE_LIGHTS);
    fill_random(PHASE_LEN);
    // widest frame, device count past the pins
    configure(2, 8, 4, 255, 15, swft_pkg::CTYPE_ARROWS);
    fill_random(PHASE_LEN);
    // zero period, zero controller width ignored, path width clipped
    configure(0, 0, 7, 0, 0, swft_pkg::CTYPE_LIGHTS);
    fill_random(PHASE_LEN);
    configure(3, 15, 1, 8'hA5, 5, swft_pkg::CTYPE_ARROWS);
    fill_random(PHASE_LEN);
    // zero path width ignored
    configure(1, 1, 0, 1, 13, swft_pkg::CTYPE_LIGHTS);
    fill_random(PHASE_LEN);
    // longest period, no bit period ever completes
    configure(65535, 2, 2, 0, 12, swft_pkg::CTYPE_ARROWS);
    push_send(8'($urandom), 4'($urandom));
    repeat (30) push_tick(1'($urandom));
    configure(2, 3, 3, 5, 7, swft_pkg::CTYPE_ARROWS);
    fill_random(PHASE_LEN);
    configure(1, 4, 2, 9, 12, swft_pkg::CTYPE_LIGHTS);
    fill_random(PHASE_LEN);

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/swft_pkg.sv
design/single_wire_frame_transceiver.sv
tb/single_wire_frame_transceiver_tb.sv
